// File: rtl/via_pkg.sv
// shared types, register codes and helpers for the interface adapter core
// no dependencies; via_tick, via_access and the core top level use this package
`timescale 1ns / 1ps

package via_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned FlagW  = 7;
  localparam int unsigned LineW  = 6;

  // request codes
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } via_req_e;

  // register map
  typedef enum logic [3:0] {
    REG_ORB    = 4'd0,
    REG_ORA    = 4'd1,
    REG_DDRB   = 4'd2,
    REG_DDRA   = 4'd3,
    REG_T1CL   = 4'd4,
    REG_T1CH   = 4'd5,
    REG_T1LL   = 4'd6,
    REG_T1LH   = 4'd7,
    REG_T2CL   = 4'd8,
    REG_T2CH   = 4'd9,
    REG_SR     = 4'd10,
    REG_ACR    = 4'd11,
    REG_PCR    = 4'd12,
    REG_IFR    = 4'd13,
    REG_IER    = 4'd14,
    REG_ORA_NH = 4'd15
  } via_reg_e;

  // interrupt flag bit positions
  localparam int unsigned FlagCa2 = 0;
  localparam int unsigned FlagCa1 = 1;
  localparam int unsigned FlagSr  = 2;
  localparam int unsigned FlagCb2 = 3;
  localparam int unsigned FlagCb1 = 4;
  localparam int unsigned FlagT2  = 5;
  localparam int unsigned FlagT1  = 6;

  // sampled line positions
  localparam int unsigned LineCa1 = 0;
  localparam int unsigned LineCa2 = 1;
  localparam int unsigned LineCb1 = 2;
  localparam int unsigned LineCb2 = 3;
  localparam int unsigned LinePb6 = 4;
  localparam int unsigned LineRst = 5;

  // timer 1 modes
  localparam logic [1:0] T1OneShot    = 2'd0;
  localparam logic [1:0] T1FreeRun    = 2'd1;
  localparam logic [1:0] T1OneShotPb7 = 2'd2;
  localparam logic [1:0] T1FreeRunPb7 = 2'd3;

  // control line modes
  localparam logic [2:0] CtlFallInp   = 3'd0;
  localparam logic [2:0] CtlRiseInp   = 3'd2;
  localparam logic [2:0] CtlHandshake = 3'd4;
  localparam logic [2:0] CtlPulse     = 3'd5;
  localparam logic [2:0] CtlLow       = 3'd6;
  localparam logic [2:0] CtlHigh      = 3'd7;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [3:0]       reg_addr;
    logic [ByteW-1:0] write_data;
    logic [ByteW-1:0] port_a_pins;
    logic [ByteW-1:0] port_b_pins;
    logic             ca1_pin;
    logic             ca2_pin;
    logic             cb1_pin;
    logic             cb2_pin;
    logic             reset_line_n;
  } via_item_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic [ByteW-1:0] port_a_out;
    logic [ByteW-1:0] port_a_dir;
    logic [ByteW-1:0] port_b_out;
    logic [ByteW-1:0] port_b_dir;
    logic             ca2_out;
    logic             cb2_out;
    logic             irq_n;
  } via_result_t;

  typedef struct packed {
    logic [ByteW-1:0]  out_a;
    logic [ByteW-1:0]  out_b;
    logic [ByteW-1:0]  dir_a;
    logic [ByteW-1:0]  dir_b;
    logic [ByteW-1:0]  lat_a;
    logic [ByteW-1:0]  lat_b;
    logic [CountW-1:0] t1_cnt;
    logic [CountW-1:0] t1_rld;
    logic              t1_act;
    logic              t1_lowp;
    logic [CountW-1:0] t2_cnt;
    logic [ByteW-1:0]  t2_lo;
    logic              t2_act;
    logic              pb7;
    logic [ByteW-1:0]  acr;
    logic [ByteW-1:0]  pcr;
    logic [FlagW-1:0]  ifr;
    logic [FlagW-1:0]  ier;
    logic [ByteW-1:0]  sr;
    logic              ca2_drv;
    logic              cb2_drv;
    logic [LineW-1:0]  prev;
  } via_state_t;

  function automatic logic edge_seen(input logic now_v, input logic old_v, input logic rise);
    return rise ? (now_v & ~old_v) : (~now_v & old_v);
  endfunction

endpackage

// File: rtl/via_ifs.sv
// request and result channel interfaces of the interface adapter core
// depends on nothing but the field widths listed here
`timescale 1ns / 1ps

interface via_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] reg_addr;
  logic [7:0] write_data;
  logic [7:0] port_a_pins;
  logic [7:0] port_b_pins;
  logic       ca1_pin;
  logic       ca2_pin;
  logic       cb1_pin;
  logic       cb2_pin;
  logic       reset_line_n;

  modport source (
    output valid, req_type, reg_addr, write_data, port_a_pins, port_b_pins,
           ca1_pin, ca2_pin, cb1_pin, cb2_pin, reset_line_n,
    input  ready
  );
  modport sink (
    input  valid, req_type, reg_addr, write_data, port_a_pins, port_b_pins,
           ca1_pin, ca2_pin, cb1_pin, cb2_pin, reset_line_n,
    output ready
  );
endinterface

interface via_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] port_a_out;
  logic [7:0] port_a_dir;
  logic [7:0] port_b_out;
  logic [7:0] port_b_dir;
  logic       ca2_out;
  logic       cb2_out;
  logic       irq_n;

  modport source (
    output valid, read_data, port_a_out, port_a_dir, port_b_out, port_b_dir,
           ca2_out, cb2_out, irq_n,
    input  ready
  );
  modport sink (
    input  valid, read_data, port_a_out, port_a_dir, port_b_out, port_b_dir,
           ca2_out, cb2_out, irq_n,
    output ready
  );
endinterface

// File: rtl/via_tick.sv
// one clock tick: timers, control line edges, handshakes and reset line
// depends on via_pkg
`timescale 1ns / 1ps

module via_tick (
  input  via_pkg::via_state_t state_i,
  input  via_pkg::via_item_t  item_i,
  output via_pkg::via_state_t state_o
);

  logic [via_pkg::LineW-1:0]  now_lines;
  logic [2:0]                 ca2_sel;
  logic [2:0]                 cb2_sel;
  logic                       t2_dec;
  logic [via_pkg::CountW-1:0] t2_next;

  assign now_lines = {item_i.reset_line_n, item_i.port_b_pins[6], item_i.cb2_pin,
                      item_i.cb1_pin, item_i.ca2_pin, item_i.ca1_pin};
  assign ca2_sel = state_i.pcr[3:1];
  assign cb2_sel = state_i.pcr[7:5];
  assign t2_dec   = state_i.acr[5] ? (state_i.prev[via_pkg::LinePb6] & ~item_i.port_b_pins[6])
                                   : 1'b1;
  assign t2_next  = t2_dec ? (state_i.t2_cnt - via_pkg::CountW'(1)) : state_i.t2_cnt;

  always_comb begin
    state_o = state_i;
    state_o.prev = now_lines;
    if (state_i.prev[via_pkg::LineRst] && !item_i.reset_line_n) begin
      // falling reset line clears everything
      state_o = '0;
      state_o.prev = now_lines;
    end else begin
      // timer 1
      if (state_i.t1_cnt <= via_pkg::CountW'(1)) begin
        state_o.t1_cnt = '0;
        if (state_i.t1_act) state_o.ifr[via_pkg::FlagT1] = 1'b1;
        unique case (state_i.acr[7:6])
          via_pkg::T1OneShot: state_o.t1_act = 1'b0;
          via_pkg::T1FreeRun: state_o.t1_cnt = state_i.t1_rld;
          via_pkg::T1OneShotPb7: begin
            state_o.t1_act = 1'b0;
            state_o.pb7    = 1'b1;
          end
          default: begin
            state_o.t1_cnt = state_i.t1_rld;
            state_o.pb7    = ~state_i.pb7;
          end
        endcase
      end else begin
        state_o.t1_cnt = state_i.t1_cnt - via_pkg::CountW'(1);
      end

      // timer 2
      state_o.t2_cnt = t2_next;
      if (state_i.t2_act && (t2_next == '0 || (t2_dec && state_i.t2_cnt == '0))) begin
        state_o.t2_cnt = '0;
        state_o.ifr[via_pkg::FlagT2] = 1'b1;
        state_o.t2_act = 1'b0;
      end

      // ca2 / cb2 input edges
      if (!ca2_sel[2] && via_pkg::edge_seen(item_i.ca2_pin, state_i.prev[via_pkg::LineCa2],
                                            ca2_sel[1])) begin
        state_o.ifr[via_pkg::FlagCa2] = 1'b1;
      end
      if (!cb2_sel[2] && via_pkg::edge_seen(item_i.cb2_pin, state_i.prev[via_pkg::LineCb2],
                                            cb2_sel[1])) begin
        state_o.ifr[via_pkg::FlagCb2] = 1'b1;
      end

      if (ca2_sel == via_pkg::CtlPulse) state_o.ca2_drv = 1'b1;
      if (cb2_sel == via_pkg::CtlPulse) state_o.cb2_drv = 1'b1;

      // ca1 / cb1 active edges
      if (via_pkg::edge_seen(item_i.ca1_pin, state_i.prev[via_pkg::LineCa1], state_i.pcr[0])) begin
        state_o.ifr[via_pkg::FlagCa1] = 1'b1;
        if (state_i.acr[0]) state_o.lat_a = item_i.port_a_pins;
        if (ca2_sel == via_pkg::CtlHandshake) state_o.ca2_drv = 1'b1;
      end
      if (via_pkg::edge_seen(item_i.cb1_pin, state_i.prev[via_pkg::LineCb1], state_i.pcr[4])) begin
        state_o.ifr[via_pkg::FlagCb1] = 1'b1;
        if (state_i.acr[1]) state_o.lat_b = item_i.port_b_pins;
        if (cb2_sel == via_pkg::CtlHandshake) state_o.cb2_drv = 1'b1;
      end
    end
  end

endmodule

// File: rtl/via_access.sv
// register read and write decode with their side effects
// depends on via_pkg
`timescale 1ns / 1ps

module via_access (
  input  via_pkg::via_state_t   state_i,
  input  via_pkg::via_item_t    item_i,
  output via_pkg::via_state_t   state_o,
  output logic [via_pkg::ByteW-1:0] rdata_o
);

  via_pkg::via_reg_e          addr;
  logic [via_pkg::ByteW-1:0]  wd;
  logic [2:0]                 ca2_sel;
  logic [2:0]                 cb2_sel;
  logic [via_pkg::ByteW-1:0]  src_a;
  logic [via_pkg::ByteW-1:0]  src_b;
  logic [via_pkg::ByteW-1:0]  pin_rd_a;
  logic [via_pkg::ByteW-1:0]  pin_rd_b;
  logic [via_pkg::CountW-1:0] t1_rld_hi;
  logic                       ca2_clr;
  logic                       cb2_clr;
  logic                       ca2_hs;

  assign addr      = via_pkg::via_reg_e'(item_i.reg_addr);
  assign wd        = item_i.write_data;
  assign ca2_sel   = state_i.pcr[3:1];
  assign cb2_sel   = state_i.pcr[7:5];
  assign src_a     = state_i.acr[0] ? state_i.lat_a : item_i.port_a_pins;
  assign src_b     = state_i.acr[1] ? state_i.lat_b : item_i.port_b_pins;
  assign pin_rd_a  = (state_i.out_a & state_i.dir_a) | (src_a & ~state_i.dir_a);
  assign pin_rd_b  = (state_i.out_b & state_i.dir_b) | (src_b & ~state_i.dir_b);
  assign t1_rld_hi = {wd, state_i.t1_rld[7:0]};
  assign ca2_clr   = (ca2_sel == via_pkg::CtlFallInp) || (ca2_sel == via_pkg::CtlRiseInp);
  assign cb2_clr   = (cb2_sel == via_pkg::CtlFallInp) || (cb2_sel == via_pkg::CtlRiseInp);
  assign ca2_hs    = (ca2_sel == via_pkg::CtlHandshake) || (ca2_sel == via_pkg::CtlPulse);

  always_comb begin
    state_o = state_i;
    rdata_o = '0;
    if (item_i.req_type == via_pkg::REQ_READ) begin
      unique case (addr)
        via_pkg::REG_ORB: begin
          state_o.ifr[via_pkg::FlagCb1] = 1'b0;
          if (cb2_clr) state_o.ifr[via_pkg::FlagCb2] = 1'b0;
          rdata_o = pin_rd_b;
        end
        via_pkg::REG_ORA: begin
          state_o.ifr[via_pkg::FlagCa1] = 1'b0;
          if (ca2_clr) state_o.ifr[via_pkg::FlagCa2] = 1'b0;
          if (ca2_hs) state_o.ca2_drv = 1'b0;
          rdata_o = pin_rd_a;
        end
        via_pkg::REG_ORA_NH: rdata_o = pin_rd_a;
        via_pkg::REG_DDRB:   rdata_o = state_i.dir_b;
        via_pkg::REG_DDRA:   rdata_o = state_i.dir_a;
        via_pkg::REG_T1CL: begin
          state_o.ifr[via_pkg::FlagT1] = 1'b0;
          rdata_o = state_i.t1_cnt[7:0];
        end
        via_pkg::REG_T1CH: rdata_o = state_i.t1_cnt[15:8];
        via_pkg::REG_T1LL: rdata_o = state_i.t1_rld[7:0];
        via_pkg::REG_T1LH: rdata_o = state_i.t1_rld[15:8];
        via_pkg::REG_T2CL: begin
          state_o.ifr[via_pkg::FlagT2] = 1'b0;
          rdata_o = state_i.t2_cnt[7:0];
        end
        via_pkg::REG_T2CH: rdata_o = state_i.t2_cnt[15:8];
        via_pkg::REG_SR: begin
          state_o.ifr[via_pkg::FlagSr] = 1'b0;
          rdata_o = state_i.sr;
        end
        via_pkg::REG_ACR: rdata_o = state_i.acr;
        via_pkg::REG_PCR: rdata_o = state_i.pcr;
        via_pkg::REG_IFR: rdata_o = {|(state_i.ifr & state_i.ier), state_i.ifr};
        via_pkg::REG_IER: rdata_o = {1'b1, state_i.ier};
        default: rdata_o = '0;
      endcase
    end else if (item_i.req_type == via_pkg::REQ_WRITE) begin
      unique case (addr)
        via_pkg::REG_ORB: begin
          state_o.out_b = wd;
          state_o.ifr[via_pkg::FlagCb1] = 1'b0;
          if (cb2_clr) state_o.ifr[via_pkg::FlagCb2] = 1'b0;
          if ((cb2_sel == via_pkg::CtlHandshake) || (cb2_sel == via_pkg::CtlPulse)) begin
            state_o.cb2_drv = 1'b0;
          end
        end
        via_pkg::REG_ORA: begin
          state_o.out_a = wd;
          state_o.ifr[via_pkg::FlagCa1] = 1'b0;
          if (ca2_clr) state_o.ifr[via_pkg::FlagCa2] = 1'b0;
          if (ca2_hs) state_o.ca2_drv = 1'b0;
        end
        via_pkg::REG_ORA_NH: state_o.out_a = wd;
        via_pkg::REG_DDRB:   state_o.dir_b = wd;
        via_pkg::REG_DDRA:   state_o.dir_a = wd;
        via_pkg::REG_T1CL: begin
          state_o.t1_rld  = {state_i.t1_rld[15:8], wd};
          state_o.t1_cnt  = {state_i.t1_cnt[15:8], wd};
          state_o.t1_lowp = 1'b1;
        end
        via_pkg::REG_T1CH: begin
          state_o.t1_rld = t1_rld_hi;
          state_o.ifr[via_pkg::FlagT1] = 1'b0;
          state_o.t1_cnt  = state_i.t1_lowp ? t1_rld_hi : {wd, state_i.t1_cnt[7:0]};
          state_o.t1_lowp = 1'b0;
          state_o.t1_act  = 1'b1;
          if (state_i.acr[7:6] == via_pkg::T1OneShotPb7) begin
            state_o.pb7 = 1'b0;
          end else if (state_i.acr[7:6] == via_pkg::T1FreeRunPb7) begin
            state_o.pb7 = ~state_i.pb7;
          end
        end
        via_pkg::REG_T1LL: begin
          state_o.t1_rld  = {state_i.t1_rld[15:8], wd};
          state_o.t1_lowp = 1'b0;
        end
        via_pkg::REG_T1LH: state_o.t1_rld = t1_rld_hi;
        via_pkg::REG_T2CL: state_o.t2_lo = wd;
        via_pkg::REG_T2CH: begin
          state_o.t2_cnt = {wd, state_i.t2_lo};
          state_o.ifr[via_pkg::FlagT2] = 1'b0;
          state_o.t2_act = 1'b1;
        end
        via_pkg::REG_SR: begin
          state_o.sr = wd;
          state_o.ifr[via_pkg::FlagSr] = 1'b0;
        end
        via_pkg::REG_ACR: state_o.acr = wd;
        via_pkg::REG_PCR: begin
          state_o.pcr = wd;
          if (wd[3:1] == via_pkg::CtlLow) state_o.ca2_drv = 1'b0;
          else if (wd[3:1] == via_pkg::CtlHigh) state_o.ca2_drv = 1'b1;
          if (wd[7:5] == via_pkg::CtlLow) state_o.cb2_drv = 1'b0;
          else if (wd[7:5] == via_pkg::CtlHigh) state_o.cb2_drv = 1'b1;
        end
        via_pkg::REG_IFR: state_o.ifr = state_i.ifr & ~wd[6:0];
        via_pkg::REG_IER: begin
          state_o.ier = wd[7] ? (state_i.ier | wd[6:0]) : (state_i.ier & ~wd[6:0]);
        end
        default: state_o = state_i;
      endcase
    end
  end

endmodule

// File: rtl/versatile_interface_adapter_core.sv
// top level of the interface adapter core: input register, state, result register
// depends on via_pkg, via_ifs (via_req_if, via_rsp_if), via_tick and via_access
//
//   channel   dir   modport            contents
//   req_i     in    via_req_if.sink    request type, address, write byte, pin levels
//   rsp_o     out   via_rsp_if.source  read byte, port values, control outputs, irq_n
//
// an accepted item waits in the input register, then its state update and
// result are formed in one pass and land in the state and result registers
// result valid rises once the item has passed the input register and lands in the
// result register; one item per cycle while the result side takes results
// the single state register closes the item-to-item loop
// rst_ni clears all state and both valid flags; payload registers are not reset
// a stalled result holds the input register, which in turn drops req_i.ready
`timescale 1ns / 1ps

module versatile_interface_adapter_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  via_req_if.sink      req_i,
  via_rsp_if.source    rsp_o
);

  // input stage
  via_pkg::via_item_t  item_q;
  logic                in_vld_q;

  // architectural state
  via_pkg::via_state_t state_q;
  via_pkg::via_state_t state_d;

  // result stage
  via_pkg::via_result_t rslt_q;
  via_pkg::via_result_t rslt_d;
  logic                 out_vld_q;

  // datapath intermediates
  via_pkg::via_state_t        ticked;
  via_pkg::via_state_t        acc_in;
  via_pkg::via_state_t        acc_out;
  logic [via_pkg::ByteW-1:0]  rdata;
  logic                       advance;
  logic                       in_take;

  // item moves into the result register when that slot is free or being emptied
  assign advance = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign in_take = req_i.valid && req_i.ready;
  assign req_i.ready = !in_vld_q || advance;

  via_tick u_tick (
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (ticked)
  );

  // writes act on the untouched state, reads on the state after their tick
  assign acc_in = (item_q.req_type == via_pkg::REQ_WRITE) ? state_q : ticked;

  via_access u_access (
    .state_i (acc_in),
    .item_i  (item_q),
    .state_o (acc_out),
    .rdata_o (rdata)
  );

  always_comb begin
    if (item_q.req_type == via_pkg::REQ_TICK) begin
      state_d = ticked;
    end else if ((item_q.req_type == via_pkg::REQ_READ) ||
                 (item_q.req_type == via_pkg::REQ_WRITE)) begin
      state_d = acc_out;
    end else begin
      // unused request code leaves state alone
      state_d = state_q;
    end
  end

  // result fields from the state this item leaves behind
  always_comb begin
    rslt_d.read_data  = (item_q.req_type == via_pkg::REQ_READ) ? rdata : '0;
    rslt_d.port_a_out = state_d.out_a;
    rslt_d.port_a_dir = state_d.dir_a;
    rslt_d.port_b_out = state_d.acr[7] ? {state_d.pb7, state_d.out_b[6:0]} : state_d.out_b;
    rslt_d.port_b_dir = state_d.dir_b;
    rslt_d.ca2_out    = state_d.pcr[3] & state_d.ca2_drv;
    rslt_d.cb2_out    = state_d.pcr[7] & state_d.cb2_drv;
    rslt_d.irq_n      = ~|(state_d.ifr & state_d.ier);
  end

  // control and state flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload flops
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type     <= req_i.req_type;
      item_q.reg_addr     <= req_i.reg_addr;
      item_q.write_data   <= req_i.write_data;
      item_q.port_a_pins  <= req_i.port_a_pins;
      item_q.port_b_pins  <= req_i.port_b_pins;
      item_q.ca1_pin      <= req_i.ca1_pin;
      item_q.ca2_pin      <= req_i.ca2_pin;
      item_q.cb1_pin      <= req_i.cb1_pin;
      item_q.cb2_pin      <= req_i.cb2_pin;
      item_q.reset_line_n <= req_i.reset_line_n;
    end
    if (advance) begin
      rslt_q <= rslt_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.read_data  = rslt_q.read_data;
  assign rsp_o.port_a_out = rslt_q.port_a_out;
  assign rsp_o.port_a_dir = rslt_q.port_a_dir;
  assign rsp_o.port_b_out = rslt_q.port_b_out;
  assign rsp_o.port_b_dir = rslt_q.port_b_dir;
  assign rsp_o.ca2_out    = rslt_q.ca2_out;
  assign rsp_o.cb2_out    = rslt_q.cb2_out;
  assign rsp_o.irq_n      = rslt_q.irq_n;

  // a waiting item is never dropped while the result side stalls
  a_hold_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q)
    else $error("input item lost while stalled");

  // every advance produces a visible result next cycle
  a_adv_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced item produced no result");

  // state only moves with an item
  a_state_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an item");

  // reported interrupt agrees with the stored flags and enables
  a_irq_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (rslt_q.irq_n == !(|(state_q.ifr & state_q.ier))))
    else $error("irq_n out of step with flag state");

endmodule

// File: verif/tb_top.sv
// self-checking bench for versatile_interface_adapter_core: ticks, reads and writes
// checked against a cycle-free predictor; depends on rtl/via_pkg.sv, rtl/via_ifs.sv and the core
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0]  ReqUnused   = 2'd3;   // request code the core ignores
  localparam int unsigned NumRandom   = 1325;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned DrainCycles = 8;      // margin past the core's input and result registers
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldStart   = 700;    // items taken before the long result stall
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned QuietLo     = 300;    // window of items with no idling at all
  localparam int unsigned QuietHi     = 500;
  localparam int unsigned IdlePct     = 30;
  localparam int unsigned MaxShown    = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  via_req_if req_if();
  via_rsp_if rsp_if();

  versatile_interface_adapter_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // predicted adapter state, all registers, timers and sampled lines
  via_pkg::via_state_t adp;

  via_pkg::via_item_t   stim_q[$];      // items waiting to be offered
  via_pkg::via_result_t due_q[$];       // predicted results, oldest first
  via_pkg::via_item_t   on_bus;         // item currently offered on the request channel
  via_pkg::via_item_t   next_item;
  int unsigned n_items;
  int unsigned n_taken;
  int unsigned n_cycles;
  int unsigned errors;
  int unsigned hold_left;
  logic        hold_done;

  // pin levels used while building stimulus
  logic [7:0] pa_lvl, pb_lvl;
  logic [3:0] ctl_lvl;         // {cb2, cb1, ca2, ca1}
  logic       rst_lvl;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic hits_edge(logic now_v, logic old_v, logic rising);
    return (now_v != old_v) && (now_v == rising);
  endfunction

  // one peripheral clock: reset line, both timers, control lines
  function automatic void run_tick(via_pkg::via_item_t it);
    logic [5:0]  was;
    logic [5:0]  lines;
    logic [2:0]  ca2_sel;
    logic [2:0]  cb2_sel;
    logic        t2_step;
    logic [15:0] t2_prior;
    was      = adp.prev;
    lines    = {it.reset_line_n, it.port_b_pins[6], it.cb2_pin, it.cb1_pin,
                it.ca2_pin, it.ca1_pin};
    ca2_sel  = adp.pcr[3:1];
    cb2_sel  = adp.pcr[7:5];

    // falling reset line wipes everything and ends the tick
    if (was[via_pkg::LineRst] && !it.reset_line_n) begin
      adp      = '0;
      adp.prev = lines;
      return;
    end
    adp.prev = lines;

    // timer 1 expires at a count of one or zero
    if (adp.t1_cnt <= 16'd1) begin
      adp.t1_cnt = '0;
      if (adp.t1_act) adp.ifr[via_pkg::FlagT1] = 1'b1;
      case (adp.acr[7:6])
        via_pkg::T1OneShot: adp.t1_act = 1'b0;
        via_pkg::T1FreeRun: adp.t1_cnt = adp.t1_rld;
        via_pkg::T1OneShotPb7: begin
          adp.t1_act = 1'b0;
          adp.pb7    = 1'b1;
        end
        default: begin
          adp.t1_cnt = adp.t1_rld;
          adp.pb7    = ~adp.pb7;
        end
      endcase
    end else begin
      adp.t1_cnt = adp.t1_cnt - 16'd1;
    end

    // timer 2 counts ticks or falling pb6 edges, wraps, fires once
    t2_step  = adp.acr[5] ? (was[via_pkg::LinePb6] && !it.port_b_pins[6]) : 1'b1;
    t2_prior = adp.t2_cnt;
    if (t2_step) adp.t2_cnt = adp.t2_cnt - 16'd1;
    if (adp.t2_act && (adp.t2_cnt == '0 || (t2_step && t2_prior == '0))) begin
      adp.t2_cnt               = '0;
      adp.ifr[via_pkg::FlagT2] = 1'b1;
      adp.t2_act               = 1'b0;
    end

    // ca2/cb2 as inputs
    if (!ca2_sel[2] && hits_edge(it.ca2_pin, was[via_pkg::LineCa2], ca2_sel[1]))
      adp.ifr[via_pkg::FlagCa2] = 1'b1;
    if (!cb2_sel[2] && hits_edge(it.cb2_pin, was[via_pkg::LineCb2], cb2_sel[1]))
      adp.ifr[via_pkg::FlagCb2] = 1'b1;

    // pulse mode releases the line on each tick
    if (ca2_sel == via_pkg::CtlPulse) adp.ca2_drv = 1'b1;
    if (cb2_sel == via_pkg::CtlPulse) adp.cb2_drv = 1'b1;

    if (hits_edge(it.ca1_pin, was[via_pkg::LineCa1], adp.pcr[0])) begin
      adp.ifr[via_pkg::FlagCa1] = 1'b1;
      if (adp.acr[0]) adp.lat_a = it.port_a_pins;
      if (ca2_sel == via_pkg::CtlHandshake) adp.ca2_drv = 1'b1;
    end
    if (hits_edge(it.cb1_pin, was[via_pkg::LineCb1], adp.pcr[4])) begin
      adp.ifr[via_pkg::FlagCb1] = 1'b1;
      if (adp.acr[1]) adp.lat_b = it.port_b_pins;
      if (cb2_sel == via_pkg::CtlHandshake) adp.cb2_drv = 1'b1;
    end
  endfunction

  function automatic void touch_port_a();
    logic [2:0] mode;
    mode = adp.pcr[3:1];
    adp.ifr[via_pkg::FlagCa1] = 1'b0;
    if (mode == via_pkg::CtlFallInp || mode == via_pkg::CtlRiseInp)
      adp.ifr[via_pkg::FlagCa2] = 1'b0;
    if (mode == via_pkg::CtlHandshake || mode == via_pkg::CtlPulse) adp.ca2_drv = 1'b0;
  endfunction

  function automatic void touch_port_b();
    logic [2:0] mode;
    mode = adp.pcr[7:5];
    adp.ifr[via_pkg::FlagCb1] = 1'b0;
    if (mode == via_pkg::CtlFallInp || mode == via_pkg::CtlRiseInp)
      adp.ifr[via_pkg::FlagCb2] = 1'b0;
  endfunction

  function automatic logic [7:0] read_byte(via_pkg::via_item_t it);
    logic [7:0] src;
    case (via_pkg::via_reg_e'(it.reg_addr))
      via_pkg::REG_ORB: begin
        touch_port_b();
        src = adp.acr[1] ? adp.lat_b : it.port_b_pins;
        return (adp.out_b & adp.dir_b) | (src & ~adp.dir_b);
      end
      via_pkg::REG_ORA, via_pkg::REG_ORA_NH: begin
        // only the handshaking address clears flags
        if (it.reg_addr == via_pkg::REG_ORA) touch_port_a();
        src = adp.acr[0] ? adp.lat_a : it.port_a_pins;
        return (adp.out_a & adp.dir_a) | (src & ~adp.dir_a);
      end
      via_pkg::REG_DDRB: return adp.dir_b;
      via_pkg::REG_DDRA: return adp.dir_a;
      via_pkg::REG_T1CL: begin
        adp.ifr[via_pkg::FlagT1] = 1'b0;
        return adp.t1_cnt[7:0];
      end
      via_pkg::REG_T1CH: return adp.t1_cnt[15:8];
      via_pkg::REG_T1LL: return adp.t1_rld[7:0];
      via_pkg::REG_T1LH: return adp.t1_rld[15:8];
      via_pkg::REG_T2CL: begin
        adp.ifr[via_pkg::FlagT2] = 1'b0;
        return adp.t2_cnt[7:0];
      end
      via_pkg::REG_T2CH: return adp.t2_cnt[15:8];
      via_pkg::REG_SR: begin
        adp.ifr[via_pkg::FlagSr] = 1'b0;
        return adp.sr;
      end
      via_pkg::REG_ACR: return adp.acr;
      via_pkg::REG_PCR: return adp.pcr;
      via_pkg::REG_IFR: return {|(adp.ifr & adp.ier), adp.ifr};
      default: return {1'b1, adp.ier};
    endcase
  endfunction

  function automatic void write_byte(logic [3:0] addr, logic [7:0] d);
    case (via_pkg::via_reg_e'(addr))
      via_pkg::REG_ORB: begin
        adp.out_b = d;
        touch_port_b();
        if (adp.pcr[7:5] == via_pkg::CtlHandshake || adp.pcr[7:5] == via_pkg::CtlPulse)
          adp.cb2_drv = 1'b0;
      end
      via_pkg::REG_ORA: begin
        adp.out_a = d;
        touch_port_a();
      end
      via_pkg::REG_DDRB: adp.dir_b = d;
      via_pkg::REG_DDRA: adp.dir_a = d;
      via_pkg::REG_T1CL: begin
        adp.t1_rld[7:0] = d;
        adp.t1_cnt[7:0] = d;
        adp.t1_lowp     = 1'b1;
      end
      via_pkg::REG_T1CH: begin
        adp.t1_rld[15:8]         = d;
        adp.ifr[via_pkg::FlagT1] = 1'b0;
        // a fresh counter-low write wins over the counter's own low byte
        if (adp.t1_lowp) adp.t1_cnt = adp.t1_rld;
        else adp.t1_cnt[15:8] = d;
        adp.t1_lowp = 1'b0;
        adp.t1_act  = 1'b1;
        if (adp.acr[7:6] == via_pkg::T1OneShotPb7) adp.pb7 = 1'b0;
        else if (adp.acr[7:6] == via_pkg::T1FreeRunPb7) adp.pb7 = ~adp.pb7;
      end
      via_pkg::REG_T1LL: begin
        adp.t1_rld[7:0] = d;
        adp.t1_lowp     = 1'b0;
      end
      via_pkg::REG_T1LH: adp.t1_rld[15:8] = d;
      via_pkg::REG_T2CL: adp.t2_lo = d;
      via_pkg::REG_T2CH: begin
        adp.t2_cnt               = {d, adp.t2_lo};
        adp.ifr[via_pkg::FlagT2] = 1'b0;
        adp.t2_act               = 1'b1;
      end
      via_pkg::REG_SR: begin
        adp.sr                   = d;
        adp.ifr[via_pkg::FlagSr] = 1'b0;
      end
      via_pkg::REG_ACR: adp.acr = d;
      via_pkg::REG_PCR: begin
        adp.pcr = d;
        if (d[3:1] == via_pkg::CtlLow) adp.ca2_drv = 1'b0;
        else if (d[3:1] == via_pkg::CtlHigh) adp.ca2_drv = 1'b1;
        if (d[7:5] == via_pkg::CtlLow) adp.cb2_drv = 1'b0;
        else if (d[7:5] == via_pkg::CtlHigh) adp.cb2_drv = 1'b1;
      end
      via_pkg::REG_IFR: adp.ifr = adp.ifr & ~d[6:0];
      via_pkg::REG_IER: begin
        if (d[7]) adp.ier = adp.ier | d[6:0];
        else adp.ier = adp.ier & ~d[6:0];
      end
      default: adp.out_a = d;
    endcase
  endfunction

  // applies one item to the predicted state and forms its result
  function automatic via_pkg::via_result_t adapter_result(via_pkg::via_item_t it);
    via_pkg::via_result_t r;
    r = '0;
    case (it.req_type)
      via_pkg::REQ_TICK: run_tick(it);
      via_pkg::REQ_READ: begin
        run_tick(it);
        r.read_data = read_byte(it);
      end
      via_pkg::REQ_WRITE: write_byte(it.reg_addr, it.write_data);
      default: ;
    endcase
    r.port_a_out = adp.out_a;
    r.port_a_dir = adp.dir_a;
    r.port_b_out = adp.acr[7] ? {adp.pb7, adp.out_b[6:0]} : adp.out_b;
    r.port_b_dir = adp.dir_b;
    r.ca2_out    = adp.pcr[3] & adp.ca2_drv;
    r.cb2_out    = adp.pcr[7] & adp.cb2_drv;
    r.irq_n      = ~|(adp.ifr & adp.ier);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void set_pins(logic [7:0] pa, logic [7:0] pb, logic [3:0] ctl,
                                   logic rst_n);
    pa_lvl  = pa;
    pb_lvl  = pb;
    ctl_lvl = ctl;
    rst_lvl = rst_n;
  endfunction

  function automatic void add_item(logic [1:0] req, logic [3:0] addr, logic [7:0] data);
    via_pkg::via_item_t it;
    it.req_type     = req;
    it.reg_addr     = addr;
    it.write_data   = data;
    it.port_a_pins  = pa_lvl;
    it.port_b_pins  = pb_lvl;
    it.ca1_pin      = ctl_lvl[0];
    it.ca2_pin      = ctl_lvl[1];
    it.cb1_pin      = ctl_lvl[2];
    it.cb2_pin      = ctl_lvl[3];
    it.reset_line_n = rst_lvl;
    stim_q.push_back(it);
  endfunction

  // control lines and pb6 move now and then so edges come at a useful rate;
  // the reset line drops rarely and comes back quickly
  function automatic void wiggle_pins();
    logic [7:0] pb_new;
    pa_lvl     = 8'($urandom_range(255));
    pb_new     = 8'($urandom_range(255));
    pb_new[6]  = pb_lvl[6] ^ ($urandom_range(99) < 30);
    pb_lvl     = pb_new;
    ctl_lvl[0] = ctl_lvl[0] ^ ($urandom_range(3) == 0);
    ctl_lvl[1] = ctl_lvl[1] ^ ($urandom_range(3) == 0);
    ctl_lvl[2] = ctl_lvl[2] ^ ($urandom_range(3) == 0);
    ctl_lvl[3] = ctl_lvl[3] ^ ($urandom_range(3) == 0);
    if (rst_lvl) rst_lvl = ($urandom_range(99) != 0);
    else rst_lvl = 1'($urandom_range(1));
  endfunction

  // timer loads are kept mostly short so the timers actually expire
  function automatic logic [7:0] write_value(logic [3:0] addr);
    if ($urandom_range(99) < 75) begin
      case (via_pkg::via_reg_e'(addr))
        via_pkg::REG_T1CL, via_pkg::REG_T1LL, via_pkg::REG_T2CL:
          return 8'($urandom_range(8));
        via_pkg::REG_T1CH, via_pkg::REG_T1LH, via_pkg::REG_T2CH:
          return 8'($urandom_range(1));
        default: ;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: offers queued items, predicts each one as it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        due_q.push_back(adapter_result(on_bus));
        n_taken <= n_taken + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        // keep offering through the long stall so the core backs up
        if (stim_q.size() != 0 &&
            ((n_taken >= QuietLo && n_taken < QuietHi) || hold_left != 0 ||
             $urandom_range(99) >= IdlePct)) begin
          next_item                = stim_q.pop_front();
          on_bus                   <= next_item;
          req_if.req_type          <= next_item.req_type;
          req_if.reg_addr          <= next_item.reg_addr;
          req_if.write_data        <= next_item.write_data;
          req_if.port_a_pins       <= next_item.port_a_pins;
          req_if.port_b_pins       <= next_item.port_b_pins;
          req_if.ca1_pin           <= next_item.ca1_pin;
          req_if.ca2_pin           <= next_item.ca2_pin;
          req_if.cb1_pin           <= next_item.cb1_pin;
          req_if.cb2_pin           <= next_item.cb2_pin;
          req_if.reset_line_n      <= next_item.reset_line_n;
          req_if.valid             <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && n_taken >= HoldStart) begin
      hold_left    <= HoldCycles;
      hold_done    <= 1'b1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= (n_taken >= QuietLo && n_taken < QuietHi) ||
                      ($urandom_range(99) >= IdlePct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    via_pkg::via_result_t got;
    via_pkg::via_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.read_data, rsp_if.port_a_out, rsp_if.port_a_dir, rsp_if.port_b_out,
             rsp_if.port_b_dir, rsp_if.ca2_out, rsp_if.cb2_out, rsp_if.irq_n};
      if (due_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= MaxShown) $display("result with nothing pending: %h", got);
      end else begin
        want = due_q.pop_front();
        if (got.read_data !== want.read_data || got.port_a_out !== want.port_a_out ||
            got.port_a_dir !== want.port_a_dir || got.port_b_out !== want.port_b_out ||
            got.port_b_dir !== want.port_b_dir || got.ca2_out !== want.ca2_out ||
            got.cb2_out !== want.cb2_out || got.irq_n !== want.irq_n) begin
          errors = errors + 1;
          if (errors <= MaxShown)
            $display("mismatch rd/pa/ddra/pb/ddrb/ca2/cb2/irq_n want %h %h %h %h %h %b %b %b",
                     want.read_data, want.port_a_out, want.port_a_dir, want.port_b_out,
                     want.port_b_dir, want.ca2_out, want.cb2_out, want.irq_n,
                     "  got %h %h %h %h %h %b %b %b",
                     got.read_data, got.port_a_out, got.port_a_dir, got.port_b_out,
                     got.port_b_dir, got.ca2_out, got.cb2_out, got.irq_n);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned k;
    int unsigned pick;
    logic [3:0]  addr;

    // every input known from time zero
    req_if.valid        = 1'b0;
    req_if.req_type     = via_pkg::REQ_TICK;
    req_if.reg_addr     = via_pkg::REG_ORB;
    req_if.write_data   = '0;
    req_if.port_a_pins  = '0;
    req_if.port_b_pins  = '0;
    req_if.ca1_pin      = 1'b0;
    req_if.ca2_pin      = 1'b0;
    req_if.cb1_pin      = 1'b0;
    req_if.cb2_pin      = 1'b0;
    req_if.reset_line_n = 1'b1;
    rsp_if.ready        = 1'b0;
    adp                 = '0;
    on_bus              = '0;
    n_taken             = 0;
    n_cycles            = 0;
    errors              = 0;
    hold_left           = 0;
    hold_done           = 1'b0;

    // directed: arm the reset line, set up handshake and pb7 modes,
    // let both timers run out, read back flags, ports, timers, sr and ier
    set_pins(8'h00, 8'h00, 4'b0000, 1'b1);
    add_item(via_pkg::REQ_TICK, via_pkg::REG_ORB, 8'h00);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_ACR, 8'hc3);  // t1 free-run on pb7, latches on
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_PCR, 8'h99);  // rising ca1/cb1, handshake
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_IER, 8'hff);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_DDRA, 8'hff);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_DDRB, 8'h0f);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_ORA, 8'ha5);  // handshake pulls ca2 low
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_ORB, 8'h00);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_T1CL, 8'h02);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_T1CH, 8'h00);
    set_pins(8'hff, 8'hff, 4'b0101, 1'b1);   // ca1 and cb1 rise, ports latched
    add_item(via_pkg::REQ_TICK, via_pkg::REG_ORB, 8'h00);
    set_pins(8'hff, 8'hbf, 4'b1111, 1'b1);   // pb6 falls, t1 expires and reloads
    add_item(via_pkg::REQ_TICK, via_pkg::REG_ORB, 8'h00);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_T2CL, 8'h01);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_T2CH, 8'h00);
    add_item(via_pkg::REQ_READ, via_pkg::REG_IFR, 8'h00);   // tick runs t2 out first
    add_item(via_pkg::REQ_READ, via_pkg::REG_ORA, 8'h00);
    add_item(via_pkg::REQ_READ, via_pkg::REG_ORB, 8'h00);
    add_item(via_pkg::REQ_READ, via_pkg::REG_ORA_NH, 8'h00);
    add_item(via_pkg::REQ_READ, via_pkg::REG_T1CL, 8'h00);
    add_item(via_pkg::REQ_READ, via_pkg::REG_T2CL, 8'h00);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_IFR, 8'h7f);
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_PCR, 8'hee);  // both control lines forced high
    add_item(via_pkg::REQ_WRITE, via_pkg::REG_SR, 8'hff);
    add_item(via_pkg::REQ_READ, via_pkg::REG_SR, 8'h00);
    add_item(ReqUnused, via_pkg::REG_IER, 8'h55);
    set_pins(8'h00, 8'h00, 4'b0000, 1'b0);   // falling reset line clears everything
    add_item(via_pkg::REQ_TICK, via_pkg::REG_ORB, 8'h00);
    set_pins(8'h00, 8'h00, 4'b0000, 1'b1);
    add_item(via_pkg::REQ_READ, via_pkg::REG_IER, 8'h00);

    // random: mostly ticks and register traffic with moving pins
    for (k = 0; k < NumRandom; k++) begin
      wiggle_pins();
      pick = $urandom_range(99);
      addr = 4'($urandom_range(15));
      if (pick < 40) add_item(via_pkg::REQ_TICK, addr, 8'($urandom_range(255)));
      else if (pick < 60) add_item(via_pkg::REQ_READ, addr, 8'($urandom_range(255)));
      else if (pick < 98) add_item(via_pkg::REQ_WRITE, addr, write_value(addr));
      else add_item(ReqUnused, addr, 8'($urandom_range(255)));
    end
    n_items = stim_q.size();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken < n_items || due_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (errors == 0 && due_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/via_pkg.sv
rtl/via_ifs.sv
rtl/via_tick.sv
rtl/via_access.sv
rtl/versatile_interface_adapter_core.sv
verif/tb_top.sv
